FILE: sv/frequency_to_midi_note_assert.svh
// assertion macros for the frequency to midi note block
// no dependencies; included by the top level
`ifndef FREQUENCY_TO_MIDI_NOTE_ASSERT_SVH
`define FREQUENCY_TO_MIDI_NOTE_ASSERT_SVH
`ifndef SYNTH
`define FMN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define FMN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FMN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FMN_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: sv/fmn_pkg.sv
// shared types, constants and elaboration-time tables for frequency_to_midi_note
// no dependencies
package fmn_pkg;

    localparam int A4_W = 17;
    localparam int BAND_W = 21;
    localparam int PITCH_W = 21;
    localparam int NOTE_W = 7;
    localparam int OCT_W = 4;
    localparam int PC_W = 4;
    localparam int FREQ_W = 21;
    localparam int STAT_W = 2;
    localparam int NSTEP = 24;
    localparam int PROD_W = 49;
    localparam int MM_W = 8;
    localparam int OCTQ_W = 4;
    localparam int IDX_W = 5;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int CFG_IDX_W = 2;
    localparam logic [63:0] Q31_ONE = 64'd1 << 31;

    localparam logic [CFG_IDX_W-1:0] CFG_A4 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_BAND  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef logic [31:0] t_q31;
    typedef t_q31 [NSTEP-1:0] t_pow_tab;
    typedef logic [PROD_W-1:0] t_prod;
    typedef t_prod [NSTEP-1:0] t_prod_tab;

    typedef struct packed {
        t_status           status;
        logic [MM_W-1:0]   mm;
    } t_loc;

    typedef struct packed {
        t_status             status;
        logic [NOTE_W-1:0]   midi_note;
        logic [OCT_W-1:0]    octave;
        logic [PC_W-1:0]     pitch_class;
        logic [FREQ_W-1:0]   note_frequency;
    } t_result;

    typedef struct packed {
        logic [3:0] quo;
        logic [3:0] rem;
    } t_dm12;

    function automatic logic [63:0] pow24_q31(input logic [63:0] x);
        logic [63:0] acc;
        logic        done;
        acc = Q31_ONE;
        done = 1'b0;
        for (int i = 0; i < 24; i++) begin
            if (!done) begin
                acc = (acc * x) >> 31;
                if (acc >= (Q31_ONE << 1)) done = 1'b1;
            end
        end
        return acc;
    endfunction

    function automatic t_pow_tab build_powers();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] t;
        t_pow_tab    tab;
        lo = Q31_ONE;
        hi = Q31_ONE + (Q31_ONE >> 4);
        for (int it = 0; it < 64; it++) begin
            if (hi - lo > 64'd1) begin
                mid = lo + ((hi - lo) >> 1);
                if (pow24_q31(mid) < (Q31_ONE << 1)) lo = mid;
                else hi = mid;
            end
        end
        t = Q31_ONE;
        tab[0] = t[31:0];
        for (int j = 1; j < NSTEP; j++) begin
            t = (t * lo + (Q31_ONE >> 1)) >> 31;
            tab[j] = t[31:0];
        end
        return tab;
    endfunction

    localparam t_pow_tab POW_TAB = build_powers();

    // quotient and remainder by twelve of a note-sized value
    function automatic t_dm12 divmod12(input logic [NOTE_W-1:0] v);
        t_dm12 r;
        r.quo = 4'd0;
        for (int i = 1; i <= 10; i++) begin
            if (v >= NOTE_W'(12 * i)) r.quo = 4'(i);
        end
        r.rem = 4'(v - NOTE_W'({r.quo, 3'b000}) - NOTE_W'({r.quo, 2'b00}));
        return r;
    endfunction

endpackage

FILE: sv/fmn_scale.sv
// table of reference_a4 * 2^(j/24) products, refilled by a sweep of one
// multiply per cycle; depends on fmn_pkg
module fmn_scale (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [fmn_pkg::A4_W-1:0] i_a4,
    output logic                     o_busy,
    output fmn_pkg::t_prod_tab       o_prod
);
    import fmn_pkg::*;

    logic                  r_busy;
    logic [IDX_W-1:0]      r_idx;
    t_prod_tab             r_prod;
    logic [63:0]           n_prod;

    assign n_prod = 64'(i_a4) * 64'(POW_TAB[r_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            if (r_idx == IDX_W'(NSTEP - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_prod[r_idx] <= n_prod[PROD_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_prod;
endmodule

FILE: sv/fmn_locate.sv
// band check and midpoint search: octave, shift, then position in octave
// depends on fmn_pkg and the product table of fmn_scale
module fmn_locate (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [fmn_pkg::PITCH_W-1:0] i_pitch,
    input  logic [fmn_pkg::A4_W-1:0]    i_a4,
    input  logic [fmn_pkg::BAND_W-1:0]  i_band_low,
    input  logic [fmn_pkg::BAND_W-1:0]  i_band_high,
    input  fmn_pkg::t_prod_tab          i_prod,
    output logic                        o_valid,
    input  logic                        i_ready,
    output fmn_pkg::t_loc               o_loc
);
    import fmn_pkg::*;

    localparam int SH_W = 57;

    logic               rdy1, rdy2, rdy3;
    logic               r_v1, r_v2, r_v3;
    t_status            r_st1, r_st2;
    logic [OCTQ_W-1:0]  r_q1, r_q2;
    logic [PITCH_W-1:0] r_f1;
    logic [SH_W-1:0]    r_fs2;
    t_loc               r_loc3;

    t_status            n_st1;
    logic [OCTQ_W-1:0]  n_q1;
    logic               found;
    logic [25:0]        f32;
    logic [4:0]         n_r;
    logic [MM_W-1:0]    n_mm;

    assign rdy3 = !r_v3 || i_ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // octave: largest q with pitch*32 >= a4 << q
    always_comb begin
        f32 = {i_pitch, 5'b00000};
        n_q1 = '0;
        found = 1'b0;
        for (int q = 0; q < 9; q++) begin
            if (f32 >= (26'(i_a4) << q)) begin
                n_q1 = OCTQ_W'(q);
                found = 1'b1;
            end
        end
        if (i_pitch == '0) n_st1 = ST_ZERO;
        else if (i_pitch < i_band_low || i_pitch > i_band_high) n_st1 = ST_BAND;
        else if (!found) n_st1 = ST_RANGE;
        else n_st1 = ST_OK;
    end

    always_comb begin
        n_r = '0;
        for (int r = 1; r < NSTEP; r++) begin
            if (r_fs2 >= SH_W'(i_prod[r])) n_r = 5'(r);
        end
        n_mm = MM_W'({r_q2, 4'b0000}) + MM_W'({r_q2, 3'b000}) + MM_W'(n_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_st1 <= n_st1;
            r_q1  <= n_q1;
            r_f1  <= i_pitch;
        end
        if (rdy2) begin
            r_st2 <= r_st1;
            r_q2  <= r_q1;
            r_fs2 <= SH_W'(r_f1) << (6'd36 - 6'(r_q1));
        end
        if (rdy3) begin
            r_loc3.status <= r_st2;
            r_loc3.mm     <= n_mm;
        end
    end

    assign o_valid = r_v3;
    assign o_loc = r_loc3;
endmodule

FILE: sv/fmn_note.sv
// note number, octave, pitch class and rounded note frequency
// depends on fmn_pkg and the product table of fmn_scale
module fmn_note (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fmn_pkg::t_loc      i_loc,
    input  fmn_pkg::t_prod_tab i_prod,
    output logic               o_valid,
    input  logic               i_ready,
    output fmn_pkg::t_result   o_res
);
    import fmn_pkg::*;

    logic               rdy4, rdy5;
    logic               r_v4, r_v5;
    t_status            r_st4;
    logic [NOTE_W-1:0]  r_n4;
    logic [OCT_W-1:0]   r_oct4;
    logic [PC_W-1:0]    r_pc4;
    logic [3:0]         r_s4;
    logic [2:0]         r_qo4;
    t_result            r_res5;

    logic [8:0]         ksum;
    logic [NOTE_W-1:0]  n_n;
    t_status            n_st4;
    t_dm12              dm_n, dm_e;
    logic [IDX_W-1:0]   pidx;
    logic [PROD_W:0]    sum;
    logic [PROD_W:0]    shd;
    t_result            n_res;

    assign rdy5 = !r_v5 || i_ready;
    assign rdy4 = !r_v4 || rdy5;
    assign o_ready = rdy4;

    always_comb begin
        ksum = 9'(i_loc.mm) + 9'd19;
        n_n = ksum[7:1];
        n_st4 = i_loc.status;
        if (i_loc.status == ST_OK && (i_loc.mm < MM_W'(23) || i_loc.mm > MM_W'(198))) begin
            n_st4 = ST_RANGE;
        end
        dm_n = divmod12(n_n);
        dm_e = divmod12(n_n - NOTE_W'(21));
    end

    always_comb begin
        pidx = {r_s4, 1'b0};
        sum = {1'b0, i_prod[pidx]} + ((PROD_W + 1)'(1) << (6'd34 - 6'(r_qo4)));
        shd = sum >> (6'd35 - 6'(r_qo4));
        n_res = '0;
        n_res.status = r_st4;
        if (r_st4 == ST_OK) begin
            n_res.midi_note   = r_n4;
            n_res.octave      = r_oct4;
            n_res.pitch_class = r_pc4;
            n_res.note_frequency = (|shd[PROD_W:FREQ_W]) ? '1 : shd[FREQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy4) r_v4 <= i_valid;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_st4  <= n_st4;
            r_n4   <= n_n;
            r_oct4 <= dm_n.quo - 4'd1;
            r_pc4  <= dm_n.rem;
            r_s4   <= dm_e.rem;
            r_qo4  <= dm_e.quo[2:0];
        end
        if (rdy5) begin
            r_res5 <= n_res;
        end
    end

    assign o_valid = r_v5;
    assign o_res = r_res5;
endmodule

FILE: sv/frequency_to_midi_note.sv
// Frequency to MIDI note converter: takes one pitch per cycle in 1/256 Hz and
// returns status, nearest equal-tempered note, octave, pitch class and the
// rounded note frequency, registered through the locate and note stages. The
// pipeline sustains one item per cycle while neither output backpressure nor a
// table fill holds it. After reset and after every write of reference_a4 the
// block refills its 24-entry table of reference products with one multiplier,
// one entry per cycle, and accepts no item until the refill is done.
`include "frequency_to_midi_note_assert.svh"
module frequency_to_midi_note #(
    parameter int FRACTION_BITS = fmn_pkg::FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [20:0] pitch
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [1:0] status, [8:2] midi_note, [12:9] octave, [16:13] pitch_class,
    // [37:17] note_frequency
    output logic [39:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [fmn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [20:0] i_cfg_data
);
    import fmn_pkg::*;

    localparam logic [63:0] A4_RAW   = 64'd440 << FRACTION_BITS;
    localparam logic [63:0] LOW_RAW  = 64'd55 << (FRACTION_BITS - 1);
    localparam logic [63:0] HIGH_RAW = 64'd4186 << FRACTION_BITS;
    localparam logic [63:0] A4_MAX   = (64'd1 << A4_W) - 64'd1;
    localparam logic [63:0] BAND_MAX = (64'd1 << BAND_W) - 64'd1;
    localparam logic [A4_W-1:0] A4_RST =
        (A4_RAW > A4_MAX) ? A4_MAX[A4_W-1:0] : A4_RAW[A4_W-1:0];
    localparam logic [BAND_W-1:0] LOW_RST =
        (LOW_RAW > BAND_MAX) ? BAND_MAX[BAND_W-1:0] : LOW_RAW[BAND_W-1:0];
    localparam logic [BAND_W-1:0] HIGH_RST =
        (HIGH_RAW > BAND_MAX) ? BAND_MAX[BAND_W-1:0] : HIGH_RAW[BAND_W-1:0];

    logic [A4_W-1:0]   r_a4;
    logic [BAND_W-1:0] r_band_low;
    logic [BAND_W-1:0] r_band_high;
    logic              cfg_wr;
    logic              start;
    logic              busy;
    t_prod_tab         prod;
    logic              loc_ready, loc_valid, note_ready;
    t_loc              loc;
    t_result           res;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid && o_cfg_ready;
    assign start = cfg_wr && (i_cfg_index == CFG_A4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a4        <= A4_RST;
            r_band_low  <= LOW_RST;
            r_band_high <= HIGH_RST;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_A4:        r_a4 <= i_cfg_data[A4_W-1:0];
                CFG_BAND_LOW:  r_band_low <= i_cfg_data;
                CFG_BAND_HIGH: r_band_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fmn_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_a4    (r_a4),
        .o_busy  (busy),
        .o_prod  (prod)
    );

    fmn_locate u_locate (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid && !busy),
        .o_ready     (loc_ready),
        .i_pitch     (i_s_axis_tdata[PITCH_W-1:0]),
        .i_a4        (r_a4),
        .i_band_low  (r_band_low),
        .i_band_high (r_band_high),
        .i_prod      (prod),
        .o_valid     (loc_valid),
        .i_ready     (note_ready),
        .o_loc       (loc)
    );

    fmn_note u_note (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (loc_valid),
        .o_ready (note_ready),
        .i_loc   (loc),
        .i_prod  (prod),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

    assign o_s_axis_tready = loc_ready && !busy;
    assign o_m_axis_tdata = {2'b00, res.note_frequency, res.pitch_class, res.octave,
                             res.midi_note, res.status};

    `FMN_ASSERT_IMP(a_ok_note, i_clk, i_rst_n, o_m_axis_tvalid && res.status == ST_OK, res.midi_note >= 7'd21 && res.midi_note <= 7'd108 && res.pitch_class < 4'd12, "note out of range")
    `FMN_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_m_axis_tvalid && res.status != ST_OK, res.midi_note == '0 && res.note_frequency == '0 && res.octave == '0, "error item not cleared")
    `FMN_ASSERT_IMP(a_busy_block, i_clk, i_rst_n, busy, !o_s_axis_tready, "item taken during table fill")
    `FMN_ASSERT_NXT(a_a4_refill, i_clk, i_rst_n, start, busy, "no table fill after reference write")
endmodule
